// File: sv/joint_pid_velocity_command_defines.svh
// ----------------------------------------------------------------------------
// joint_pid_velocity_command_defines
// Assertion macros shared by the joint velocity controller RTL.
// ----------------------------------------------------------------------------
`ifndef JOINT_PID_VELOCITY_COMMAND_DEFINES_SVH
`define JOINT_PID_VELOCITY_COMMAND_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define JPVC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define JPVC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/jpvc_pkg.sv
// ----------------------------------------------------------------------------
// jpvc_pkg
// Widths, constants and shared types of the joint velocity controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package jpvc_pkg;

  // joint count and per-joint store addressing
  localparam int JOINTS = 8;
  localparam int MEM_AW = (JOINTS > 1) ? $clog2(JOINTS) : 1;

  // field widths
  localparam int IDX_W   = 3;
  localparam int POS_W   = 32;
  localparam int VEL_W   = 18;
  localparam int INTEG_W = 18;
  localparam int GAIN_W  = 16;
  localparam int RATE_W  = 10;
  localparam int LIM_W   = 64;
  localparam int LIMF_W  = 16;

  // stream payload widths
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 56;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_GAIN_P      = 3'd0;
  localparam cfg_idx_t REG_GAIN_D      = 3'd1;
  localparam cfg_idx_t REG_GAIN_I      = 3'd2;
  localparam cfg_idx_t REG_RATE_HZ     = 3'd3;
  localparam cfg_idx_t REG_PERIOD_FRAC = 3'd4;
  localparam cfg_idx_t REG_LIMITS_LO   = 3'd5;
  localparam cfg_idx_t REG_LIMITS_HI   = 3'd6;

  // register reset values
  localparam logic [GAIN_W-1:0] RST_GAIN_P      = 16'd1280;
  localparam logic [GAIN_W-1:0] RST_GAIN_D      = 16'd128;
  localparam logic [GAIN_W-1:0] RST_GAIN_I      = 16'd26;
  localparam logic [RATE_W-1:0] RST_RATE_HZ     = 10'd20;
  localparam logic [GAIN_W-1:0] RST_PERIOD_FRAC = 16'd3277;
  localparam logic [LIM_W-1:0]  RST_LIMITS_LO   = 64'd1152939097061327258;
  localparam logic [LIM_W-1:0]  RST_LIMITS_HI   = 64'd1152939097061330944;

  // tolerances in Q16.16
  localparam logic signed [POS_W-1:0] REACH_TOL = 32'sd1310;
  localparam logic signed [POS_W-1:0] INTEG_TOL = 32'sd6553;
  localparam logic signed [INTEG_W:0] INTEG_MAX = 19'sd65536;
  localparam logic [16:0]             VEL_MAX   = 17'd65536;

  // per-joint store write request
  typedef struct packed {
    logic                        we;
    logic [MEM_AW-1:0]           addr;
    logic signed [INTEG_W-1:0]   integ;
    logic signed [POS_W-1:0]     err;
  } mem_wr_t;

  // per-joint store read data
  typedef struct packed {
    logic signed [INTEG_W-1:0]   integ;
    logic signed [POS_W-1:0]     err;
  } mem_rd_t;

endpackage

// File: sv/jpvc_state_mem.sv
// ----------------------------------------------------------------------------
// jpvc_state_mem
// Per-joint integral and last-error store: one synchronous memory with a
// registered read, plus per-entry valid bits so that a restart clears all.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jpvc_state_mem (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      clear_all,
  input  logic                      rd_en,
  input  logic [jpvc_pkg::MEM_AW-1:0] rd_addr,
  output jpvc_pkg::mem_rd_t         rd_data,
  input  jpvc_pkg::mem_wr_t         wr
);
  import jpvc_pkg::*;

  localparam int ENTRY_W = INTEG_W + POS_W;

  logic [ENTRY_W-1:0] mem_r [JOINTS];
  logic [JOINTS-1:0]  valid_r;
  logic [ENTRY_W-1:0] rd_word_r;
  logic               rd_ok_r;

  // memory write port
  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem_r[wr.addr] <= {wr.integ, wr.err};
    end
  end

  // memory read port, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_word_r <= mem_r[rd_addr];
    end
  end

  // valid bits: cleared by reset or restart, set on write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      rd_ok_r <= 1'b0;
    end else begin
      if (clear_all) begin
        valid_r <= '0;
      end
      if (wr.we) begin
        valid_r[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_ok_r <= valid_r[rd_addr] & ~clear_all;
      end
    end
  end

  // an entry never written since the last clear reads as zero
  assign rd_data = rd_ok_r ? mem_rd_t'(rd_word_r) : '0;

endmodule

// File: sv/joint_pid_velocity_command.sv
// ----------------------------------------------------------------------------
// joint_pid_velocity_command
// Per-joint PID velocity controller with integral anti-windup and limits.
// ----------------------------------------------------------------------------
// Input stream (in_*): one joint sample per transaction; in_tuser is the
// restart flag that clears every stored integral and last error first, and
// in_tlast marks the final joint of a control cycle.
// Output stream (out_*): one result per sample: clamped velocity command and
// saturated position error in out_tdata, the running all-joints-reached flag
// in out_tuser and a copy of the cycle mark in out_tlast.
// Configuration: cfg_we writes cfg_wdata to the register chosen by cfg_index
// (gains, rate, period, limits); write only while the block is idle, which the block does not enforce.
// One sample is in work at a time; the next is taken the cycle after the
// result is loaded. The sample rate is set by the multiply sequence over
// the read-modify-write of the per-joint state memory.
// The output register lets a new sample enter while a result waits; a stall
// on out_tready holds the sequencer in its last step until the slot frees.
// Reset restores the configuration registers, the sequencer state and the
// output valid bit, clears the per-joint state at once through valid bits
// and sets the reached flag; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "joint_pid_velocity_command_defines.svh"

module joint_pid_velocity_command (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration write port
  input  logic                                 cfg_we,
  input  logic [jpvc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [jpvc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  // input stream
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // joint_index[2:0], target_position[34:3], measured_position[66:35], zero
  input  logic [jpvc_pkg::IN_TDATA_W-1:0]      in_tdata,
  // restart[0]
  input  logic                                 in_tuser,
  input  logic                                 in_tlast,
  // output stream
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // joint_velocity[17:0], position_error[49:18], zero
  output logic [jpvc_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // all_reached[0]
  output logic                                 out_tuser,
  output logic                                 out_tlast
);
  import jpvc_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_ERR  = 7'b0000010,
    ST_MUL1 = 7'b0000100,
    ST_MUL2 = 7'b0001000,
    ST_MUL3 = 7'b0010000,
    ST_SUM  = 7'b0100000,
    ST_OUT  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic [GAIN_W-1:0] gain_p_r, gain_d_r, gain_i_r, period_frac_r;
  logic [RATE_W-1:0] rate_hz_r;
  logic [LIM_W-1:0]  limits_lo_r, limits_hi_r;

  // captured sample
  logic [IDX_W-1:0]        idx_r;
  logic                    idx_ok_r;
  logic signed [POS_W-1:0] tgt_r, meas_r;
  logic                    last_r;

  // datapath registers
  logic signed [POS_W-1:0]    e_r;
  logic signed [48:0]         pterm_r;
  logic [25:0]                kdr_r;
  logic signed [31:0]         incprod_r;
  logic signed [32:0]         diff_r;
  logic                       in_win_r;
  logic                       reached_r;
  logic [16:0]                lim_r;
  logic signed [59:0]         dterm_r;
  logic signed [INTEG_W-1:0]  integ_new_r;
  logic signed [34:0]         iterm_r;
  logic signed [52:0]         vel_sum_r;
  logic                       reached_so_far_r;

  // output register
  logic                    out_valid_r;
  logic [VEL_W-1:0]        out_vel_r;
  logic [POS_W-1:0]        out_err_r;
  logic                    out_reached_r;
  logic                    out_last_r;

  // handshake and memory interface
  logic        in_fire;
  logic        in_idx_ok;
  logic        out_free;
  mem_rd_t     mem_rd;
  mem_wr_t     mem_wr;

  // combinational intermediates
  logic signed [32:0]        err_full;
  logic signed [POS_W-1:0]   err_sat;
  logic [LIM_W-1:0]          lim_word;
  logic [LIMF_W-1:0]         lim_field;
  logic [19:0]               lim_x16;
  logic signed [32:0]        inc_round;
  logic signed [INTEG_W:0]   integ_sum;
  logic signed [60:0]        pid_sum;
  logic signed [52:0]        lim_pos, lim_neg;
  logic [VEL_W-1:0]          vel_clamped;
  logic                      reached_all;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign in_idx_ok = (32'(in_tdata[IDX_W-1:0]) < JOINTS);
  assign out_free  = !out_valid_r || out_tready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r      <= RST_GAIN_P;
      gain_d_r      <= RST_GAIN_D;
      gain_i_r      <= RST_GAIN_I;
      rate_hz_r     <= RST_RATE_HZ;
      period_frac_r <= RST_PERIOD_FRAC;
      limits_lo_r   <= RST_LIMITS_LO;
      limits_hi_r   <= RST_LIMITS_HI;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GAIN_P:      gain_p_r      <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_D:      gain_d_r      <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_I:      gain_i_r      <= cfg_wdata[GAIN_W-1:0];
        REG_RATE_HZ:     rate_hz_r     <= cfg_wdata[RATE_W-1:0];
        REG_PERIOD_FRAC: period_frac_r <= cfg_wdata[GAIN_W-1:0];
        REG_LIMITS_LO:   limits_lo_r   <= cfg_wdata;
        REG_LIMITS_HI:   limits_hi_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // per-joint state memory, read at acceptance, written back in MUL3
  jpvc_state_mem u_state_mem (
    .clk       (clk),
    .rst_n     (rst_n),
    .clear_all (in_fire && in_tuser),
    .rd_en     (in_fire),
    .rd_addr   (MEM_AW'(in_tdata[IDX_W-1:0])),
    .rd_data   (mem_rd),
    .wr        (mem_wr)
  );

  always_comb begin
    mem_wr.we    = (state_r == ST_MUL3) && idx_ok_r;
    mem_wr.addr  = MEM_AW'(idx_r);
    mem_wr.integ = integ_new_r;
    mem_wr.err   = e_r;
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_fire) state_nxt = ST_ERR;
      ST_ERR:  state_nxt = ST_MUL1;
      ST_MUL1: state_nxt = ST_MUL2;
      ST_MUL2: state_nxt = ST_MUL3;
      ST_MUL3: state_nxt = ST_SUM;
      ST_SUM:  state_nxt = ST_OUT;
      ST_OUT:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // sample capture
  always_ff @(posedge clk) begin
    if (in_fire) begin
      idx_r    <= in_tdata[IDX_W-1:0];
      idx_ok_r <= in_idx_ok;
      tgt_r    <= $signed(in_tdata[IDX_W +: POS_W]);
      meas_r   <= $signed(in_tdata[IDX_W+POS_W +: POS_W]);
      last_r   <= in_tlast;
    end
  end

  // saturated error
  always_comb begin
    err_full = $signed({tgt_r[POS_W-1], tgt_r}) - $signed({meas_r[POS_W-1], meas_r});
    if (err_full[32] != err_full[31]) begin
      err_sat = err_full[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      err_sat = err_full[31:0];
    end
  end

  // joint velocity limit, saturated to 1.0
  always_comb begin
    lim_word  = idx_r[2] ? limits_hi_r : limits_lo_r;
    lim_field = lim_word[LIMF_W*idx_r[1:0] +: LIMF_W];
    lim_x16   = {lim_field, 4'b0000};
  end

  // integral update with window and clamp
  always_comb begin
    inc_round = 33'(incprod_r) + 33'sd32768;
    integ_sum = 19'(mem_rd.integ) + 19'($signed(inc_round[32:16]));
  end

  // pid sum with half-up rounding of the Q8.8 gains
  always_comb begin
    pid_sum = 61'(pterm_r) + 61'(dterm_r) + 61'(iterm_r) + 61'sd128;
  end

  // final clamp and reach tracking
  always_comb begin
    lim_pos = $signed({36'd0, lim_r});
    lim_neg = -lim_pos;
    if (!idx_ok_r) begin
      vel_clamped = '0;
    end else if (vel_sum_r > lim_pos) begin
      vel_clamped = lim_pos[VEL_W-1:0];
    end else if (vel_sum_r < lim_neg) begin
      vel_clamped = lim_neg[VEL_W-1:0];
    end else begin
      vel_clamped = vel_sum_r[VEL_W-1:0];
    end
    reached_all = idx_ok_r ? (reached_so_far_r && reached_r) : reached_so_far_r;
  end

  // datapath steps
  always_ff @(posedge clk) begin
    case (state_r)
      ST_ERR: begin
        e_r <= err_sat;
      end
      ST_MUL1: begin
        pterm_r   <= $signed({1'b0, gain_p_r}) * e_r;
        kdr_r     <= gain_d_r * rate_hz_r;
        incprod_r <= $signed(e_r[14:0]) * $signed({1'b0, period_frac_r});
        diff_r    <= $signed({e_r[POS_W-1], e_r}) - $signed({mem_rd.err[POS_W-1], mem_rd.err});
        in_win_r  <= (e_r <= INTEG_TOL) && (e_r >= -INTEG_TOL);
        reached_r <= (e_r <= REACH_TOL) && (e_r >= -REACH_TOL);
        lim_r     <= (lim_x16 > 20'(VEL_MAX)) ? VEL_MAX : lim_x16[16:0];
      end
      ST_MUL2: begin
        dterm_r <= $signed({1'b0, kdr_r}) * diff_r;
        if (!in_win_r) begin
          integ_new_r <= '0;
        end else if (integ_sum > INTEG_MAX) begin
          integ_new_r <= INTEG_MAX[INTEG_W-1:0];
        end else if (integ_sum < -INTEG_MAX) begin
          integ_new_r <= 18'(-INTEG_MAX);
        end else begin
          integ_new_r <= integ_sum[INTEG_W-1:0];
        end
      end
      ST_MUL3: begin
        iterm_r <= $signed({1'b0, gain_i_r}) * integ_new_r;
      end
      ST_SUM: begin
        vel_sum_r <= pid_sum[60:8];
      end
      default: ;
    endcase
  end

  // output register and reached flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r      <= 1'b0;
      reached_so_far_r <= 1'b1;
    end else begin
      if ((state_r == ST_OUT) && out_free) begin
        out_valid_r      <= 1'b1;
        reached_so_far_r <= last_r ? 1'b1 : reached_all;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_OUT) && out_free) begin
      out_vel_r     <= vel_clamped;
      out_err_r     <= e_r;
      out_reached_r <= reached_all;
      out_last_r    <= last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_err_r, out_vel_r};
  assign out_tuser  = out_reached_r;
  assign out_tlast  = out_last_r;

  // design checks
  `JPVC_ASSERT_NEXT(a_single_item, in_fire, !in_tready, "second sample taken while one in work")
  `JPVC_ASSERT_NOW(a_wb_timing, mem_wr.we, $past(in_fire, 4), "state write-back out of step")
  `JPVC_ASSERT_NOW(a_out_source, $rose(out_tvalid), $past(state_r == ST_OUT), "result not from last step")

endmodule
